@@ design/fqdn_pkg.sv @@
// shared constants and codes for the keyed fifo queue with dequeue-n
package fqdn_pkg;

  // store geometry
  localparam int DEPTH     = 16;
  localparam int KEY_WIDTH = 16;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // item field widths
  localparam int CMD_W    = 2;
  localparam int KEY_IN_W = 16;
  localparam int TAG_W    = 8;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;
  localparam int REM_W    = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DQN = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADCNT = 2'd3;

endpackage

@@ design/fqdn_in_if.sv @@
// command channel: valid/ready handshake with one command item
interface fqdn_in_if;
  logic                         valid;
  logic                         ready;
  logic [fqdn_pkg::CMD_W-1:0]    cmd;
  logic [fqdn_pkg::KEY_IN_W-1:0] key;
  logic [fqdn_pkg::TAG_W-1:0]    tag;
  logic [fqdn_pkg::COUNT_W-1:0]  count;

  modport source (output valid, cmd, key, tag, count, input ready);
  modport sink   (input valid, cmd, key, tag, count, output ready);
endinterface

@@ design/fqdn_out_if.sv @@
// result channel: valid/ready handshake with one result item
interface fqdn_out_if;
  logic                         valid;
  logic                         ready;
  logic [fqdn_pkg::STATUS_W-1:0] status;
  logic [fqdn_pkg::KEY_IN_W-1:0] max_key;
  logic [fqdn_pkg::TAG_W-1:0]    max_tag;
  logic [fqdn_pkg::REM_W-1:0]    remaining;

  modport source (output valid, status, max_key, max_tag, remaining, input ready);
  modport sink   (input valid, status, max_key, max_tag, remaining, output ready);
endinterface

@@ design/fqdn_ram.sv @@
// generic single-write, single-read ram with registered read data
module fqdn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/fifo_queue_dequeue_n_max_core.sv @@
// top level of the keyed fifo queue with dequeue-n keep-maximum
// enqueue, dequeue, rejected and unused commands: straight to S_DONE, result loaded there
// dequeue-n: one store read per removed entry through the single ram read port,
//   entries compared in S_SCAN, then the result loaded in S_DONE
// one item in flight: no new item before its result is loaded, later while a result waits
// synchronous reset empties the queue (head and count to zero); store contents are kept
module fifo_queue_dequeue_n_max_core (
  input  logic            clk,
  input  logic            rst,
  fqdn_in_if.sink         req,
  fqdn_out_if.source      rsp
);

  localparam int DEPTH    = fqdn_pkg::DEPTH;
  localparam int KW       = fqdn_pkg::KEY_WIDTH;
  localparam int KIW      = fqdn_pkg::KEY_IN_W;
  localparam int TW       = fqdn_pkg::TAG_W;
  localparam int PTR_W    = fqdn_pkg::PTR_W;
  localparam int CNT_W    = fqdn_pkg::CNT_W;
  localparam int COUNT_W  = fqdn_pkg::COUNT_W;
  localparam int REM_W    = fqdn_pkg::REM_W;
  localparam int STATUS_W = fqdn_pkg::STATUS_W;
  // compare width wide enough for both the requested count and the occupancy
  localparam int CMP_W    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W+1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t              state;
  logic [PTR_W-1:0]    head_pointer;
  logic [CNT_W-1:0]    entry_count;
  logic [CNT_W-1:0]    seen;
  logic [CNT_W-1:0]    n_reg;
  logic [STATUS_W-1:0] res_status;
  logic [KW-1:0]       best_key;
  logic [TW-1:0]       best_tag;

  logic                accept;
  logic                is_full;
  logic                bad_count;
  logic [CNT_W-1:0]    seen_inc;
  logic                ram_wr_en;
  logic [PTR_W-1:0]    ram_wr_addr;
  logic [PTR_W-1:0]    ram_rd_addr;
  logic [KW+TW-1:0]    ram_rd_data;
  logic [KW-1:0]       rd_key;
  logic [TW-1:0]       rd_tag;

  // ring index: pointer plus offset, offset never above DEPTH so one wrap suffices
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(ptr) + (CNT_W+1)'(off);
    if (s >= DEPTH_SUM) begin
      s = s - DEPTH_SUM;
    end
    return PTR_W'(s);
  endfunction

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign is_full   = (entry_count == DEPTH_CNT);
  // zero or more than the occupancy, which covers the empty queue too
  assign bad_count = (CMP_W'(req.count) == '0) || (CMP_W'(req.count) > CMP_W'(entry_count));
  assign seen_inc  = seen + CNT_W'(1);

  // tail write happens in the accept cycle
  assign ram_wr_en   = accept && (req.cmd == fqdn_pkg::CMD_ENQ) && !is_full;
  assign ram_wr_addr = wrap_add(head_pointer, entry_count);

  // read port runs one entry ahead of the compare: head while idle, next offset while scanning
  assign ram_rd_addr = (state == S_SCAN) ? wrap_add(head_pointer, seen_inc) : head_pointer;

  assign rd_key = ram_rd_data[TW +: KW];
  assign rd_tag = ram_rd_data[TW-1:0];

  fqdn_ram #(
    .WIDTH (KW + TW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data ({KW'(req.key), req.tag}),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head_pointer <= '0;
      entry_count  <= '0;
      rsp.valid    <= 1'b0;
    end else begin
      // result taken downstream, unless a new one is loaded this cycle
      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        rsp.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            res_status <= fqdn_pkg::ST_OK;
            best_key   <= '0;
            best_tag   <= '0;
            seen       <= '0;
            n_reg      <= CNT_W'(req.count);
            state      <= S_DONE;
            case (req.cmd)
              fqdn_pkg::CMD_ENQ: begin
                if (is_full) begin
                  res_status <= fqdn_pkg::ST_FULL;
                end else begin
                  entry_count <= entry_count + CNT_W'(1);
                end
              end
              fqdn_pkg::CMD_DEQ: begin
                if (entry_count == '0) begin
                  res_status <= fqdn_pkg::ST_EMPTY;
                end else begin
                  head_pointer <= wrap_add(head_pointer, CNT_W'(1));
                  entry_count  <= entry_count - CNT_W'(1);
                end
              end
              fqdn_pkg::CMD_DQN: begin
                if (bad_count) begin
                  res_status <= fqdn_pkg::ST_BADCNT;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                // unused code: no operation, ok status
              end
            endcase
          end
        end

        S_SCAN: begin
          // later entry wins on equal keys
          if ((seen == '0) || (rd_key >= best_key)) begin
            best_key <= rd_key;
            best_tag <= rd_tag;
          end
          seen <= seen_inc;
          if (seen_inc == n_reg) begin
            head_pointer <= wrap_add(head_pointer, n_reg);
            entry_count  <= entry_count - n_reg;
            state        <= S_DONE;
          end
        end

        S_DONE: begin
          // output register free, or emptying this cycle
          if (!rsp.valid || rsp.ready) begin
            rsp.valid     <= 1'b1;
            rsp.status    <= res_status;
            rsp.max_key   <= KIW'(best_key);
            rsp.max_tag   <= best_tag;
            rsp.remaining <= REM_W'(entry_count);
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/fqdn_checker.sv @@
// port-level checks for the keyed fifo queue, bound to the top level
module fqdn_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [fqdn_pkg::STATUS_W-1:0] rsp_status,
  input logic [fqdn_pkg::KEY_IN_W-1:0] rsp_max_key,
  input logic [fqdn_pkg::TAG_W-1:0]    rsp_max_tag,
  input logic [fqdn_pkg::REM_W-1:0]    rsp_remaining
);

  // a pending result stays until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped before it was taken");

  // one item at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item accepted while one is in flight");

  // a new result is only loaded while the input side is closed
  a_rsp_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("result appeared without a busy cycle");

  // an empty report means nothing is left
  a_empty_remaining: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == fqdn_pkg::ST_EMPTY) |-> (rsp_remaining == '0))
    else $error("empty status with entries left");

  // failed commands carry no maximum
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != fqdn_pkg::ST_OK) |-> (rsp_max_key == '0) && (rsp_max_tag == '0))
    else $error("failed command returned a maximum");

endmodule

bind fifo_queue_dequeue_n_max_core fqdn_checker u_fqdn_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_max_key   (rsp.max_key),
  .rsp_max_tag   (rsp.max_tag),
  .rsp_remaining (rsp.remaining)
);

@@ bench/tb_top.sv @@
// testbench for the keyed fifo queue: directed and random commands checked against a queue predictor
`timescale 1ns / 100ps

module tb_top;
  import fqdn_pkg::*;

  // code 3 is not used by the block: it is a no-op that still returns a result
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  // worst case is a dequeue-n of the whole queue plus stalls on both sides;
  // the limit is taken many times over that
  localparam int unsigned RUN_LIMIT = 200000;
  // dequeue-n is the longest item, settle for twice its worst case at the end
  localparam int SETTLE_CYCLES = 2 * (DEPTH + 2);
  // share of cycles, out of a hundred, in which a side idles
  localparam int IDLE_SHARE = 37;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [KEY_IN_W-1:0] key;
    logic [TAG_W-1:0]    tag;
    logic [COUNT_W-1:0]  count;
  } cmd_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_IN_W-1:0] max_key;
    logic [TAG_W-1:0]    max_tag;
    logic [REM_W-1:0]    remaining;
  } queue_result_t;

  logic clk;
  logic rst;

  fqdn_in_if  req_if ();
  fqdn_out_if rsp_if ();

  fifo_queue_dequeue_n_max_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // shadow copy of the queue, updated as each command is accepted
  logic [KEY_WIDTH-1:0] shadow_keys [DEPTH];
  logic [TAG_W-1:0]     shadow_tags [DEPTH];
  int                   shadow_head = 0;
  int                   shadow_fill = 0;

  // results still owed by the block, oldest first
  queue_result_t pending_results [$];

  int          mismatch_count    = 0;
  int          results_checked   = 0;
  int unsigned cycle_count       = 0;
  // when set, neither side idles
  bit          steady_flow       = 1'b0;
  // receiver hold-off, counted down once per cycle
  int          stall_cycles_left = 0;

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // run limit: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // works out the result of one command and moves the shadow queue on
  function automatic queue_result_t predict_queue_op(input cmd_item_t item);
    queue_result_t        res;
    int                   slot;
    logic [KEY_WIDTH-1:0] best_key;
    logic [TAG_W-1:0]     best_tag;
    res        = '0;
    res.status = ST_OK;
    best_key   = '0;
    best_tag   = '0;
    case (item.cmd)
      CMD_ENQ: begin
        if (shadow_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot = (shadow_head + shadow_fill) % DEPTH;
          shadow_keys[slot] = item.key[KEY_WIDTH-1:0];
          shadow_tags[slot] = item.tag;
          shadow_fill++;
        end
      end
      CMD_DEQ: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_fill--;
        end
      end
      CMD_DQN: begin
        if (item.count == 0 || item.count > shadow_fill) begin
          res.status = ST_BADCNT;
        end else begin
          // scan from the head; on equal keys the later entry takes over
          for (int i = 0; i < item.count; i++) begin
            slot = (shadow_head + i) % DEPTH;
            if (i == 0 || shadow_keys[slot] >= best_key) begin
              best_key = shadow_keys[slot];
              best_tag = shadow_tags[slot];
            end
          end
          res.max_key = KEY_IN_W'(best_key);
          res.max_tag = best_tag;
          shadow_head = (shadow_head + item.count) % DEPTH;
          shadow_fill -= item.count;
        end
      end
      default: ; // unused code leaves the queue alone
    endcase
    res.remaining = REM_W'(shadow_fill);
    return res;
  endfunction

  function automatic cmd_item_t make_item(input logic [CMD_W-1:0] cmd,
                                          input logic [KEY_IN_W-1:0] key,
                                          input logic [TAG_W-1:0] tag,
                                          input logic [COUNT_W-1:0] count);
    cmd_item_t item;
    item.cmd   = cmd;
    item.key   = key;
    item.tag   = tag;
    item.count = count;
    return item;
  endfunction

  // mostly well-formed traffic: enqueues, dequeues and dequeue-n with a legal count,
  // with a little noise (wild counts, the unused code) mixed in;
  // fill_bias tilts the mix towards enqueue so the queue reaches full
  function automatic cmd_item_t random_command(input bit fill_bias);
    cmd_item_t item;
    int        pick;
    int        enq_share;
    enq_share  = fill_bias ? 70 : 35;
    item.key   = ($urandom_range(0, 3) == 0) ? KEY_IN_W'($urandom_range(0, 7))
                                             : KEY_IN_W'($urandom_range(0, 65535));
    item.tag   = TAG_W'($urandom_range(0, 255));
    item.count = COUNT_W'($urandom_range(0, 31));
    pick       = $urandom_range(0, 99);
    if (pick < enq_share) begin
      item.cmd = CMD_ENQ;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        item.cmd = CMD_DEQ;
      end else if (pick < 80) begin
        item.cmd   = CMD_DQN;
        item.count = (shadow_fill == 0) ? COUNT_W'(1)
                                        : COUNT_W'($urandom_range(1, shadow_fill));
      end else if (pick < 92) begin
        item.cmd = CMD_DQN; // wild count, usually rejected
      end else begin
        item.cmd = CMD_NOP;
      end
    end
    return item;
  endfunction

  // offers one item and waits for it to be taken; returns at the next falling edge
  // with valid still high, so back-to-back items only drop valid when the sender idles
  task automatic send_item(input cmd_item_t item);
    if (!steady_flow) begin
      while ($urandom_range(0, 99) < IDLE_SHARE) begin
        req_if.valid <= 1'b0;
        @(negedge clk);
      end
    end
    req_if.valid <= 1'b1;
    req_if.cmd   <= item.cmd;
    req_if.key   <= item.key;
    req_if.tag   <= item.tag;
    req_if.count <= item.count;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    pending_results.push_back(predict_queue_op(item));
    @(negedge clk);
  endtask

  // sender stops until every owed result has come back
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("tb_top: mismatch at result %0d: %s", results_checked, what);
  endtask

  // receiver: random stalls, none during a steady stretch, held low during a hold-off
  initial begin : drive_ready
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready <= (stall_cycles_left == 0) &&
                      (steady_flow || $urandom_range(0, 99) >= IDLE_SHARE);
    end
  end

  always @(posedge clk) begin
    if (stall_cycles_left > 0) stall_cycles_left <= stall_cycles_left - 1;
  end

  // every result taken is compared with the oldest one owed
  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, status %0d", rsp_if.status));
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", rsp_if.status, want.status));
        if (rsp_if.max_key !== want.max_key)
          report_mismatch($sformatf("max_key %h, want %h", rsp_if.max_key, want.max_key));
        if (rsp_if.max_tag !== want.max_tag)
          report_mismatch($sformatf("max_tag %h, want %h", rsp_if.max_tag, want.max_tag));
        if (rsp_if.remaining !== want.remaining)
          report_mismatch($sformatf("remaining %0d, want %0d",
                                    rsp_if.remaining, want.remaining));
      end
    end
  end

  // empty queue: dequeue reports empty, dequeue-n reports bad count, unused code is a no-op
  task automatic test_empty_queue();
    send_item(make_item(CMD_DEQ, 16'hffff, 8'hff, 5'd0));
    send_item(make_item(CMD_DQN, 16'h0000, 8'h00, 5'd1));
    send_item(make_item(CMD_NOP, 16'ha5a5, 8'h5a, 5'd31));
  endtask

  // fill to the brim with extreme keys and a tie on the top key, then overflow once
  task automatic test_fill_to_full();
    logic [KEY_IN_W-1:0] key;
    logic [TAG_W-1:0]    tag;
    for (int i = 0; i < DEPTH; i++) begin
      key = KEY_IN_W'(i * 257);
      tag = TAG_W'(i);
      if (i == 0) key = 16'h0000;
      if (i == 2) begin key = 16'hffff; tag = 8'h11; end
      if (i == 7) begin key = 16'hffff; tag = 8'hee; end // later of the tie must win
      if (i == DEPTH - 1) tag = 8'hff;
      send_item(make_item(CMD_ENQ, key, tag, 5'd0));
    end
    send_item(make_item(CMD_ENQ, 16'h1234, 8'h56, 5'd0));
  endtask

  // counts of zero and above the fill are refused; then the whole queue in one go, then one enqueue and dequeue
  task automatic test_dequeue_n_limits();
    send_item(make_item(CMD_DQN, 16'h0000, 8'h00, 5'd0));
    send_item(make_item(CMD_DQN, 16'h0000, 8'h00, 5'd17));
    send_item(make_item(CMD_DQN, 16'h0000, 8'h00, 5'd16));
    send_item(make_item(CMD_ENQ, 16'h8000, 8'h80, 5'd0));
    send_item(make_item(CMD_DEQ, 16'h0000, 8'h00, 5'd0));
  endtask

  // receiver holds off for a long stretch while commands keep coming,
  // so the output register fills and the input stalls
  task automatic test_backpressure();
    stall_cycles_left = 80;
    for (int i = 0; i < 12; i++) send_item(random_command(i < 8));
  endtask

  // sender pauses with the block drained, then carries on
  task automatic test_pause_for_results();
    wait_for_results();
    for (int i = 0; i < 6; i++) send_item(random_command(1'b0));
    wait_for_results();
  endtask

  // random traffic, alternating stretches that fill and drain the queue
  task automatic test_random_commands(input int num_items);
    for (int i = 0; i < num_items; i++) send_item(random_command(((i / 25) % 2) == 0));
  endtask

  // random traffic with no idling on either side
  task automatic test_steady_stream(input int num_items);
    steady_flow = 1'b1;
    test_random_commands(num_items);
    steady_flow = 1'b0;
  endtask

  initial begin : run_tests
    rst          = 1'b1;
    req_if.valid = 1'b0;
    req_if.cmd   = CMD_NOP;
    req_if.key   = '0;
    req_if.tag   = '0;
    req_if.count = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_queue();
    test_fill_to_full();
    test_dequeue_n_limits();
    test_backpressure();
    test_pause_for_results();
    test_random_commands(150);
    test_steady_stream(100);
    test_random_commands(200);

    // drain, then give the block time to show any stray result
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/fqdn_pkg.sv
design/fqdn_in_if.sv
design/fqdn_out_if.sv
design/fqdn_ram.sv
design/fifo_queue_dequeue_n_max_core.sv
design/fqdn_checker.sv
bench/tb_top.sv
